/* design/ptpa_pkg.sv */
// package for the pan/tilt pointing angle pipeline
// widths, register indexes, cordic angle table and fixed-point constants
`timescale 1ns / 1ps
package ptpa_pkg;
    localparam int POS_W      = 17;
    localparam int DIFF_W     = 18;
    localparam int YAW_W      = 10;
    localparam int PAN_W      = 16;
    localparam int TILT_W     = 15;
    localparam int VIS_W      = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 17;
    localparam int XW         = 44;
    localparam int ZW         = 27;
    localparam int CDEG_W     = 18;
    localparam int PRESCALE_SH = 20;
    localparam int ANG_FRAC   = 16;
    localparam int GAIN_Q16   = 107922;
    localparam int GAIN_W     = 18;
    localparam int ATAN_ENTRIES = 24;
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int VIS_HALF   = 128;

    localparam logic signed [ZW-1:0] ANG_180 = ZW'(180 * 65536);
    localparam logic signed [ZW-1:0] ANG_360 = ZW'(360 * 65536);

    localparam logic [CFG_IDX_W-1:0] REG_CAM_X    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_Y    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_Z    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_YAW  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_MIN  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_MAX  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_MIN = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_MAX = 4'd7;

    function automatic logic signed [ZW-1:0] atan_ent(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = ZW'(2949120);
            1:  v = ZW'(1740967);
            2:  v = ZW'(919879);
            3:  v = ZW'(466945);
            4:  v = ZW'(234379);
            5:  v = ZW'(117304);
            6:  v = ZW'(58666);
            7:  v = ZW'(29335);
            8:  v = ZW'(14668);
            9:  v = ZW'(7334);
            10: v = ZW'(3667);
            11: v = ZW'(1833);
            12: v = ZW'(917);
            13: v = ZW'(458);
            14: v = ZW'(229);
            15: v = ZW'(115);
            16: v = ZW'(57);
            17: v = ZW'(29);
            18: v = ZW'(14);
            19: v = ZW'(7);
            20: v = ZW'(4);
            21: v = ZW'(2);
            22: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

/* design/ptpa_vector.sv */
// cordic vectoring pipeline: quadrant fold stage then one stage per iteration
// depends on ptpa_pkg for widths and the angle table
`timescale 1ns / 1ps
module ptpa_vector import ptpa_pkg::*; #(
    parameter int STAGES = DEF_CORDIC_STAGES,
    parameter int SBW    = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic [SBW-1:0]       i_sb,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [ZW-1:0] o_ang,
    output logic signed [XW-1:0] o_len,
    output logic [SBW-1:0]       o_sb
);
    logic                 r_v    [0:STAGES];
    logic signed [XW-1:0] r_x    [0:STAGES];
    logic signed [XW-1:0] r_y    [0:STAGES];
    logic signed [ZW-1:0] r_z    [0:STAGES];
    logic                 r_zero [0:STAGES];
    logic [SBW-1:0]       r_sb   [0:STAGES];
    logic                 w_en   [0:STAGES];

    assign w_en[STAGES] = !r_v[STAGES] || i_ready;
    assign w_en[0] = !r_v[0] || w_en[1];
    assign o_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_en[0]) begin
            r_v[0] <= i_valid;
        end
        if (w_en[0]) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            r_sb[0]   <= i_sb;
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= (i_y >= 0) ? ANG_180 : -ANG_180;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar k = 1; k <= STAGES; k++) begin : g_iter
        logic signed [XW-1:0] w_xs, w_ys;
        logic                 w_pos;
        if (k < STAGES) begin : g_en
            assign w_en[k] = !r_v[k] || w_en[k+1];
        end
        assign w_xs  = r_x[k-1] >>> (k - 1);
        assign w_ys  = r_y[k-1] >>> (k - 1);
        assign w_pos = !r_y[k-1][XW-1] && (r_y[k-1] != '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_v[k] <= r_v[k-1];
            end
            if (w_en[k]) begin
                r_zero[k] <= r_zero[k-1];
                r_sb[k]   <= r_sb[k-1];
                if (w_pos) begin
                    r_x[k] <= r_x[k-1] + w_ys;
                    r_y[k] <= r_y[k-1] - w_xs;
                    r_z[k] <= r_z[k-1] + atan_ent(k - 1);
                end else begin
                    r_x[k] <= r_x[k-1] - w_ys;
                    r_y[k] <= r_y[k-1] + w_xs;
                    r_z[k] <= r_z[k-1] - atan_ent(k - 1);
                end
            end
        end
    end

    assign o_valid = r_v[STAGES];
    assign o_sb    = r_sb[STAGES];
    assign o_ang   = r_zero[STAGES] ? '0 : r_z[STAGES];
    assign o_len   = r_zero[STAGES] ? '0 : r_x[STAGES];
endmodule

/* design/ptpa_clamp.sv */
// output stage: angle to centidegrees, limit clamp and result register
// depends on ptpa_pkg for widths
`timescale 1ns / 1ps
module ptpa_clamp import ptpa_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [ZW-1:0]     i_pan_ang,
    input  logic signed [ZW-1:0]     i_tilt_ang,
    input  logic                     i_tv,
    input  logic signed [PAN_W-1:0]  i_pan_min,
    input  logic signed [PAN_W-1:0]  i_pan_max,
    input  logic signed [TILT_W-1:0] i_tilt_min,
    input  logic signed [TILT_W-1:0] i_tilt_max,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [PAN_W-1:0]  o_pan_cdeg,
    output logic signed [TILT_W-1:0] o_tilt_cdeg,
    output logic                     o_target_valid,
    output logic                     o_pan_limited,
    output logic                     o_tilt_limited
);
    function automatic logic signed [CDEG_W-1:0] to_cdeg(input logic signed [ZW-1:0] a);
        logic signed [ZW+8:0] p;
        p = (ZW+9)'(a) * (ZW+9)'(100) + (ZW+9)'(32768);
        return p[ANG_FRAC +: CDEG_W];
    endfunction

    logic signed [CDEG_W-1:0] w_pan_raw, w_tilt_raw, w_pan_lo, w_pan_hi, w_tilt_lo, w_tilt_hi;
    logic signed [CDEG_W-1:0] w_pan_a, w_pan_c, w_tilt_a, w_tilt_c;
    logic                     r_valid, w_en;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_valid;

    always_comb begin
        w_pan_raw  = to_cdeg(i_pan_ang);
        w_tilt_raw = to_cdeg(i_tilt_ang);
        w_pan_lo   = CDEG_W'(i_pan_min);
        w_pan_hi   = CDEG_W'(i_pan_max);
        w_tilt_lo  = CDEG_W'(i_tilt_min);
        w_tilt_hi  = CDEG_W'(i_tilt_max);
        w_pan_a    = (w_pan_raw < w_pan_lo) ? w_pan_lo : w_pan_raw;
        w_pan_c    = (w_pan_a > w_pan_hi) ? w_pan_hi : w_pan_a;
        w_tilt_a   = (w_tilt_raw < w_tilt_lo) ? w_tilt_lo : w_tilt_raw;
        w_tilt_c   = (w_tilt_a > w_tilt_hi) ? w_tilt_hi : w_tilt_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
        if (w_en) begin
            o_target_valid <= i_tv;
            o_pan_cdeg     <= i_tv ? w_pan_c[PAN_W-1:0] : '0;
            o_tilt_cdeg    <= i_tv ? w_tilt_c[TILT_W-1:0] : '0;
            o_pan_limited  <= i_tv && (w_pan_c != w_pan_raw);
            o_tilt_limited <= i_tv && (w_tilt_c != w_tilt_raw);
        end
    end
endmodule

/* design/pan_tilt_pointing_angles.sv */
// throughput: one item per cycle unless i_ready holds the output, set by
// the two unrolled cordic pipelines
// each stage advances when empty or when the next stage takes its item
// reset (synchronous, active low) empties the pipeline and loads the default
// camera position, yaw and angle limits
`timescale 1ns / 1ps
module pan_tilt_pointing_angles import ptpa_pkg::*; #(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [POS_W-1:0]  i_ball_x_mm,
    input  logic signed [POS_W-1:0]  i_ball_y_mm,
    input  logic signed [POS_W-1:0]  i_ball_z_mm,
    input  logic [VIS_W-1:0]         i_visibility,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [PAN_W-1:0]  o_pan_cdeg,
    output logic signed [TILT_W-1:0] o_tilt_cdeg,
    output logic                     o_target_valid,
    output logic                     o_pan_limited,
    output logic                     o_tilt_limited,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);
    logic signed [POS_W-1:0]  r_cam_x, r_cam_y, r_cam_z;
    logic signed [YAW_W-1:0]  r_cam_yaw;
    logic signed [PAN_W-1:0]  r_pan_min, r_pan_max;
    logic signed [TILT_W-1:0] r_tilt_min, r_tilt_max;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x    <= '0;
            r_cam_y    <= '0;
            r_cam_z    <= '0;
            r_cam_yaw  <= '0;
            r_pan_min  <= PAN_W'(-18000);
            r_pan_max  <= PAN_W'(18000);
            r_tilt_min <= TILT_W'(-9000);
            r_tilt_max <= TILT_W'(9000);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CAM_X:    r_cam_x    <= i_cfg_data[POS_W-1:0];
                REG_CAM_Y:    r_cam_y    <= i_cfg_data[POS_W-1:0];
                REG_CAM_Z:    r_cam_z    <= i_cfg_data[POS_W-1:0];
                REG_CAM_YAW:  r_cam_yaw  <= i_cfg_data[YAW_W-1:0];
                REG_PAN_MIN:  r_pan_min  <= i_cfg_data[PAN_W-1:0];
                REG_PAN_MAX:  r_pan_max  <= i_cfg_data[PAN_W-1:0];
                REG_TILT_MIN: r_tilt_min <= i_cfg_data[TILT_W-1:0];
                REG_TILT_MAX: r_tilt_max <= i_cfg_data[TILT_W-1:0];
                default: ;
            endcase
        end
    end

    // yaw folded into 0..359 degrees
    logic signed [YAW_W+1:0] w_yaw_a, w_yaw_m;
    always_comb begin
        w_yaw_a = (YAW_W+2)'(r_cam_yaw);
        if (w_yaw_a < 0) begin
            w_yaw_a = w_yaw_a + (YAW_W+2)'(360);
        end
        if (w_yaw_a < 0) begin
            w_yaw_m = w_yaw_a + (YAW_W+2)'(360);
        end else if (w_yaw_a >= (YAW_W+2)'(360)) begin
            w_yaw_m = w_yaw_a - (YAW_W+2)'(360);
        end else begin
            w_yaw_m = w_yaw_a;
        end
    end

    // stage 1: differences
    logic                     r_s1_v, r_s1_tv, w_s1_en;
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_dz;
    // stage 2: prescale and gain multiply
    logic                     r_s2_v, r_s2_tv, w_s2_en;
    logic signed [XW-1:0]     r_s2_x, r_s2_y, r_s2_yz;
    logic signed [2*GAIN_W-1:0] w_prod;

    logic                 w_p1_ready, w_p1_valid;
    logic signed [ZW-1:0] w_p1_ang;
    logic signed [XW-1:0] w_p1_len;
    logic [XW:0]          w_p1_sb;

    logic                 r_s3_v, r_s3_tv, w_s3_en, w_p2_ready;

    assign w_s2_en = !r_s2_v || w_p1_ready;
    assign w_s1_en = !r_s1_v || w_s2_en;
    assign o_ready = w_s1_en;
    assign w_prod  = r_dz * $signed(GAIN_W'(GAIN_Q16));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (w_s1_en) begin
                r_s1_v <= i_valid;
            end
            if (w_s2_en) begin
                r_s2_v <= r_s1_v;
            end
        end
        if (w_s1_en) begin
            r_dx    <= DIFF_W'(i_ball_x_mm) - DIFF_W'(r_cam_x);
            r_dy    <= DIFF_W'(i_ball_y_mm) - DIFF_W'(r_cam_y);
            r_dz    <= DIFF_W'(i_ball_z_mm) - DIFF_W'(r_cam_z);
            r_s1_tv <= (i_visibility > VIS_W'(VIS_HALF));
        end
        if (w_s2_en) begin
            r_s2_x  <= XW'(r_dx) <<< PRESCALE_SH;
            r_s2_y  <= XW'(r_dy) <<< PRESCALE_SH;
            r_s2_yz <= XW'(w_prod) <<< (PRESCALE_SH - ANG_FRAC);
            r_s2_tv <= r_s1_tv;
        end
    end

    ptpa_vector #(.STAGES(CORDIC_STAGES), .SBW(XW + 1)) u_pan_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_v),
        .o_ready (w_p1_ready),
        .i_x     (r_s2_x),
        .i_y     (r_s2_y),
        .i_sb    ({r_s2_yz, r_s2_tv}),
        .o_valid (w_p1_valid),
        .i_ready (w_s3_en),
        .o_ang   (w_p1_ang),
        .o_len   (w_p1_len),
        .o_sb    (w_p1_sb)
    );

    // stage 3: yaw offset and wrap into (-180, 180]
    logic signed [ZW-1:0] r_pan;
    logic signed [XW-1:0] r_s3_len, r_s3_yz;
    logic signed [ZW:0]   w_p, w_pan;

    assign w_s3_en = !r_s3_v || w_p2_ready;

    always_comb begin
        w_p = (ZW+1)'(w_p1_ang) - ((ZW+1)'(w_yaw_m) <<< ANG_FRAC);
        if (w_p > (ZW+1)'(ANG_180)) begin
            w_pan = w_p - (ZW+1)'(ANG_360);
        end else if (w_p + (ZW+1)'(ANG_360) <= -(ZW+1)'(ANG_180)) begin
            w_pan = w_p + ((ZW+1)'(ANG_360) <<< 1);
        end else if (w_p <= -(ZW+1)'(ANG_180)) begin
            w_pan = w_p + (ZW+1)'(ANG_360);
        end else begin
            w_pan = w_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (w_s3_en) begin
            r_s3_v <= w_p1_valid;
        end
        if (w_s3_en) begin
            // ball straight above or below the camera
            r_pan    <= (w_p1_len == '0) ? '0 : w_pan[ZW-1:0];
            r_s3_len <= w_p1_len;
            r_s3_yz  <= w_p1_sb[XW:1];
            r_s3_tv  <= w_p1_sb[0];
        end
    end

    logic                 w_p2_valid, w_out_ready;
    logic signed [ZW-1:0] w_p2_ang;
    logic signed [XW-1:0] w_p2_len;
    logic [ZW:0]          w_p2_sb;

    ptpa_vector #(.STAGES(CORDIC_STAGES), .SBW(ZW + 1)) u_tilt_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_v),
        .o_ready (w_p2_ready),
        .i_x     (r_s3_len),
        .i_y     (r_s3_yz),
        .i_sb    ({r_pan, r_s3_tv}),
        .o_valid (w_p2_valid),
        .i_ready (w_out_ready),
        .o_ang   (w_p2_ang),
        .o_len   (w_p2_len),
        .o_sb    (w_p2_sb)
    );

    logic w_len_unused;
    assign w_len_unused = ^w_p2_len;

    ptpa_clamp u_clamp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_p2_valid),
        .o_ready        (w_out_ready),
        .i_pan_ang      (w_p2_sb[ZW:1]),
        .i_tilt_ang     (w_p2_ang),
        .i_tv           (w_p2_sb[0] | (w_len_unused & 1'b0)),
        .i_pan_min      (r_pan_min),
        .i_pan_max      (r_pan_max),
        .i_tilt_min     (r_tilt_min),
        .i_tilt_max     (r_tilt_max),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pan_cdeg     (o_pan_cdeg),
        .o_tilt_cdeg    (o_tilt_cdeg),
        .o_target_valid (o_target_valid),
        .o_pan_limited  (o_pan_limited),
        .o_tilt_limited (o_tilt_limited)
    );

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_s1_v)
        else $error("accepted transfer lost at first stage");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_target_valid) |->
        (o_pan_cdeg == '0 && o_tilt_cdeg == '0 && !o_pan_limited && !o_tilt_limited))
        else $error("invalid target with nonzero result");
endmodule

/* tb/ptpa_checker.sv */
// checker for the pan/tilt pointing angle pipeline: predicts each result
// from observed config and input transfers and compares output transfers
// depends on ptpa_pkg
`timescale 1ns / 1ps
module ptpa_checker import ptpa_pkg::*; #(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic                     i_in_ready,
    input  logic signed [POS_W-1:0]  i_ball_x_mm,
    input  logic signed [POS_W-1:0]  i_ball_y_mm,
    input  logic signed [POS_W-1:0]  i_ball_z_mm,
    input  logic [VIS_W-1:0]         i_visibility,
    input  logic                     i_out_valid,
    input  logic                     i_ready,
    input  logic signed [PAN_W-1:0]  i_pan_cdeg,
    input  logic signed [TILT_W-1:0] i_tilt_cdeg,
    input  logic                     i_target_valid,
    input  logic                     i_pan_limited,
    input  logic                     i_tilt_limited,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    output int                       o_errors,
    output int                       o_pending
);
    typedef struct packed {
        logic signed [PAN_W-1:0]  pan;
        logic signed [TILT_W-1:0] tilt;
        logic                     tv;
        logic                     pl;
        logic                     tl;
    } t_angles;

    t_angles angle_q[$];
    longint cam_x, cam_y, cam_z, yaw, pan_lo, pan_hi, tilt_lo, tilt_hi;

    assign o_pending = angle_q.size();

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_tab(int i);
        longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
            4, 2, 1, 0};
        return t[i];
    endfunction

    function automatic void cordic_vec(longint x, longint y, output longint ang,
                                       output longint len);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) begin
            ang = 0;
            len = 0;
            return;
        end
        if (x < 0) begin
            z = (y >= 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES && i < ATAN_ENTRIES; i++) begin
            xs = shr(x, i);
            ys = shr(y, i);
            if (y > 0) begin
                x += ys; y -= xs; z += longint'(atan_tab(i));
            end else begin
                x -= ys; y += xs; z -= longint'(atan_tab(i));
            end
        end
        ang = z;
        len = x;
    endfunction

    function automatic t_angles predict_angles(longint bx, longint by, longint bz,
                                               int vis);
        t_angles r;
        longint dx, dy, dz, phi, len, tang, tlen, pan, yz, pc, tc, pv, tvv;
        r = '0;
        if (vis <= VIS_HALF) return r;
        dx = bx - cam_x;
        dy = by - cam_y;
        dz = bz - cam_z;
        cordic_vec(dx * 1048576, dy * 1048576, phi, len);
        if (dx == 0 && dy == 0) pan = 0;
        else begin
            pan = phi - yaw * 65536;
            while (pan > 180 * 65536) pan -= 360 * 65536;
            while (pan <= -180 * 65536) pan += 360 * 65536;
        end
        yz = shr(dz * 1048576 * GAIN_Q16 + 32768, 16);
        cordic_vec(len, yz, tang, tlen);
        pv = shr(pan * 100 + 32768, 16);
        tvv = shr(tang * 100 + 32768, 16);
        pc = pv;
        if (pc < pan_lo) pc = pan_lo;
        if (pc > pan_hi) pc = pan_hi;
        tc = tvv;
        if (tc < tilt_lo) tc = tilt_lo;
        if (tc > tilt_hi) tc = tilt_hi;
        r.pan = PAN_W'(pc);
        r.tilt = TILT_W'(tc);
        r.tv = 1'b1;
        r.pl = (pc != pv);
        r.tl = (tc != tvv);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_angles e, a;
        if (!i_rst_n) begin
            cam_x = 0; cam_y = 0; cam_z = 0; yaw = 0;
            pan_lo = -18000; pan_hi = 18000; tilt_lo = -9000; tilt_hi = 9000;
            angle_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_CAM_X:    cam_x = longint'(signed'(i_cfg_data[16:0]));
                    REG_CAM_Y:    cam_y = longint'(signed'(i_cfg_data[16:0]));
                    REG_CAM_Z:    cam_z = longint'(signed'(i_cfg_data[16:0]));
                    REG_CAM_YAW:  yaw = longint'(signed'(i_cfg_data[9:0]));
                    REG_PAN_MIN:  pan_lo = longint'(signed'(i_cfg_data[15:0]));
                    REG_PAN_MAX:  pan_hi = longint'(signed'(i_cfg_data[15:0]));
                    REG_TILT_MIN: tilt_lo = longint'(signed'(i_cfg_data[14:0]));
                    REG_TILT_MAX: tilt_hi = longint'(signed'(i_cfg_data[14:0]));
                    default: ;
                endcase
            end
            if (i_out_valid && i_ready) begin
                a = '{i_pan_cdeg, i_tilt_cdeg, i_target_valid, i_pan_limited,
                      i_tilt_limited};
                if (angle_q.size() == 0) begin
                    $display("%0t: unexpected result actual %p", $time, a);
                    o_errors <= o_errors + 1;
                end else begin
                    e = angle_q.pop_front();
                    if (a !== e) begin
                        $display("%0t: mismatch expected %p actual %p", $time, e, a);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && i_in_ready)
                angle_q.push_back(predict_angles(longint'(i_ball_x_mm),
                    longint'(i_ball_y_mm), longint'(i_ball_z_mm), int'(i_visibility)));
        end
    end
endmodule

/* tb/tb_pan_tilt_pointing_angles.sv */
// testbench top for the pan/tilt pointing angle pipeline: directed and random
// positions under several camera settings, with random idling on both sides
// depends on ptpa_pkg, pan_tilt_pointing_angles and ptpa_checker
`timescale 1ns / 1ps
module tb_pan_tilt_pointing_angles;
    import ptpa_pkg::*;

    localparam int LATENCY = 2 * DEF_CORDIC_STAGES + 6;
    localparam int LIMIT = 400000;

    logic i_clk = 1'b0, i_rst_n = 1'b0;
    logic i_valid = 1'b0, i_ready = 1'b0, i_cfg_valid = 1'b0;
    logic signed [POS_W-1:0] i_ball_x_mm = '0, i_ball_y_mm = '0, i_ball_z_mm = '0;
    logic [VIS_W-1:0] i_visibility = '0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic o_ready, o_valid, o_target_valid, o_pan_limited, o_tilt_limited, o_cfg_ready;
    logic signed [PAN_W-1:0] o_pan_cdeg;
    logic signed [TILT_W-1:0] o_tilt_cdeg;
    int errors, pending, cycles = 0;
    int send_idle = 0, recv_idle = 0;

    always #10 i_clk = ~i_clk;

    pan_tilt_pointing_angles dut (.*);

    ptpa_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_in_ready(o_ready), .i_ball_x_mm,
        .i_ball_y_mm, .i_ball_z_mm, .i_visibility, .i_out_valid(o_valid), .i_ready,
        .i_pan_cdeg(o_pan_cdeg), .i_tilt_cdeg(o_tilt_cdeg), .i_target_valid(o_target_valid),
        .i_pan_limited(o_pan_limited), .i_tilt_limited(o_tilt_limited), .i_cfg_valid,
        .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data, .o_errors(errors),
        .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        if (i_rst_n) i_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_pos(int x, int y, int z, int vis);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ball_x_mm <= POS_W'(x);
        i_ball_y_mm <= POS_W'(y);
        i_ball_z_mm <= POS_W'(z);
        i_visibility <= VIS_W'(vis);
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic setup_camera(int x, int y, int z, int yw, int plo, int phi,
                                int tlo, int thi);
        write_reg(REG_CAM_X, x);
        write_reg(REG_CAM_Y, y);
        write_reg(REG_CAM_Z, z);
        write_reg(REG_CAM_YAW, yw);
        write_reg(REG_PAN_MIN, plo);
        write_reg(REG_PAN_MAX, phi);
        write_reg(REG_TILT_MIN, tlo);
        write_reg(REG_TILT_MAX, thi);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int rand_pos(bit near);
        if (near) return $signed($urandom_range(4000)) - 2000;
        return $signed($urandom_range(131071)) - 65536;
    endfunction

    task automatic random_items(int n);
        int vis;
        for (int k = 0; k < n; k++) begin
            vis = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(255, 129);
            send_pos(rand_pos($urandom_range(1)), rand_pos($urandom_range(1)),
                     rand_pos($urandom_range(1)), vis);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle = 34;
        recv_idle = 70;
        send_pos(0, 0, 0, 255);
        send_pos(0, 0, 500, 255);
        send_pos(0, 0, -500, 200);
        send_pos(65535, 65535, 65535, 255);
        send_pos(-65536, -65536, -65536, 255);
        send_pos(-65536, 0, 0, 255);
        send_pos(-65536, -1, 0, 255);
        send_pos(0, -65536, 65535, 129);
        send_pos(1000, 1000, 0, 128);
        send_pos(1000, 1000, 0, 0);
        send_pos(-1, 1, -1, 130);
        drain();
        setup_camera(-65536, 65535, -65536, 360, 5000, -5000, 3000, -3000);
        send_pos(0, 0, 0, 255);
        send_pos(-65536, 65535, -65536, 255);
        send_pos(65535, -65536, 65535, 255);
        send_pos(-65536, 65535, 65535, 255);
        drain();
        setup_camera(65535, -65536, 65535, -360, -18000, 18000, -9000, 9000);
        send_pos(-65536, 65535, -65536, 255);
        send_pos(65535, -65536, 0, 255);
        send_pos(0, 0, 0, 255);
        drain();
        setup_camera(100, -200, 300, 45, -9000, 9000, -4500, 4500);
        random_items(250);
        drain();
        send_idle = 70;
        recv_idle = 34;
        setup_camera(-3000, 2500, -800, -170, 18000, -18000, 9000, -9000);
        random_items(250);
        drain();
        setup_camera(0, 0, 0, 91, -1200, 1500, -600, 800);
        random_items(150);
        drain();
        send_idle = 0;
        recv_idle = 0;
        for (int p = 0; p < 4; p++) begin
            setup_camera(rand_pos(1), rand_pos(1), rand_pos(1),
                $signed($urandom_range(720)) - 360, $signed($urandom_range(36000)) - 18000,
                $signed($urandom_range(36000)) - 18000, $signed($urandom_range(18000)) - 9000,
                $signed($urandom_range(18000)) - 9000);
            random_items(100);
            drain();
        end
        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule
